@@ src/led_twinkle_marquee_overlay_top_assert.svh @@
// ----------------------------------------------------------------------------
// led_twinkle_marquee_overlay_top_assert.svh
// Assertion macros used by the overlay top RTL.
// ----------------------------------------------------------------------------
`ifndef LED_TWINKLE_MARQUEE_OVERLAY_TOP_ASSERT_SVH
`define LED_TWINKLE_MARQUEE_OVERLAY_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define LTMO_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overlay assertion failed");

// Next-cycle implication, disabled in reset
`define LTMO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overlay assertion failed");

`endif

@@ src/ltmo_pkg.sv @@
// ----------------------------------------------------------------------------
// ltmo_pkg
// Types, constants and the marquee quarter table for the overlay block.
// ----------------------------------------------------------------------------
package ltmo_pkg;

    localparam int COL_W    = 6;
    localparam int WORD_W   = 16;
    localparam int PERIOD_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TWINKLE_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARQUEE_PERIOD = 1'd1;

    localparam logic [WORD_W-1:0] TOP_BIT    = 16'h0001;
    localparam logic [WORD_W-1:0] BOTTOM_BIT = 16'h0800;

    typedef struct packed {
        logic [PERIOD_W-1:0] twinkle_period;
        logic [PERIOD_W-1:0] marquee_period;
        logic [PERIOD_W-1:0] twinkle_count;
        logic [PERIOD_W-1:0] marquee_count;
    } ltmo_ctrl_t;

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] last_word;
        logic [1:0]        top_phase;
        logic [1:0]        bottom_phase;
    } quarter_look_t;

    function automatic quarter_look_t quarter_look(input logic [1:0] quarter);
        quarter_look_t q;
        unique case (quarter)
            2'd0: q = '{16'h0111, 16'h0222, 2'd0, 2'd1};
            2'd1: q = '{16'h0222, 16'h0111, 2'd3, 2'd2};
            2'd2: q = '{16'h0444, 16'h0888, 2'd2, 2'd3};
            2'd3: q = '{16'h0888, 16'h0444, 2'd1, 2'd0};
            default: q = '{16'h0111, 16'h0222, 2'd0, 2'd1};
        endcase
        return q;
    endfunction

endpackage

@@ src/led_twinkle_marquee_overlay_top.sv @@
// ----------------------------------------------------------------------------
// led_twinkle_marquee_overlay_top
// Column stream overlay: twinkle blanking and animated marquee border.
// ----------------------------------------------------------------------------
// One column word is taken per clock while s_tready is high; sustained rate
// is one transaction per cycle while m_tready also stays high. The overlay
// is computed from the frame counters as they stand when the column is
// accepted and lands in a two-entry output buffer (output register plus skid
// register), so input is refused only once both entries are full. Counters
// with a nonzero period advance on the transaction carrying column COLUMNS-1.
module led_twinkle_marquee_overlay_top
    import ltmo_pkg::*;
#(
    parameter int COLUMNS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [5:0] column_index, [21:6] column_word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_W-1:0]    m_tdata,   // [15:0] shown_word
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_data
);

    `include "led_twinkle_marquee_overlay_top_assert.svh"

    localparam int CMP_W = 9;
    localparam logic [CMP_W-1:0] LAST_COL = CMP_W'(COLUMNS - 1);

    logic [PERIOD_W-1:0] twinkle_period_reg;
    logic [PERIOD_W-1:0] marquee_period_reg;
    logic [PERIOD_W-1:0] twinkle_count_reg, twinkle_count_next;
    logic [PERIOD_W-1:0] marquee_count_reg, marquee_count_next;
    logic                m_valid_reg, m_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [WORD_W-1:0]   m_data_reg;
    logic [WORD_W-1:0]   skid_data_reg;

    logic [COL_W-1:0]    column_index;
    logic [WORD_W-1:0]   column_word;
    logic [WORD_W-1:0]   shown_word;
    logic                is_last;
    logic                in_fire;
    logic                out_fire;
    logic [PERIOD_W-1:0] twinkle_inc;
    logic [PERIOD_W-1:0] marquee_inc;
    ltmo_ctrl_t          ctrl;

    assign column_index = s_tdata[COL_W-1:0];
    assign column_word  = s_tdata[COL_W+WORD_W-1:COL_W];
    assign is_last      = ({{(CMP_W-COL_W){1'b0}}, column_index} == LAST_COL);

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_valid_reg && m_tready;

    assign ctrl = '{twinkle_period_reg, marquee_period_reg,
                    twinkle_count_reg, marquee_count_reg};

    ltmo_overlay u_overlay
    (
        .ctrl         (ctrl),
        .column_index (column_index),
        .column_word  (column_word),
        .is_last      (is_last),
        .shown_word   (shown_word)
    );

    assign twinkle_inc = twinkle_count_reg + 8'd1;
    assign marquee_inc = marquee_count_reg + 8'd1;

    always_comb
    begin
        twinkle_count_next = twinkle_count_reg;
        marquee_count_next = marquee_count_reg;
        if (in_fire && is_last)
        begin
            if (twinkle_period_reg != '0)
                twinkle_count_next = (twinkle_inc >= twinkle_period_reg) ? '0 : twinkle_inc;
            if (marquee_period_reg != '0)
                marquee_count_next = (marquee_inc >= marquee_period_reg) ? '0 : marquee_inc;
        end
    end

    // Output register takes fresh data when empty or draining; else skid holds it
    always_comb
    begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire)
        begin
            m_valid_next    = skid_valid_reg || in_fire;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            if (m_valid_reg)
                skid_valid_next = 1'b1;
            else
                m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twinkle_period_reg <= '0;
            marquee_period_reg <= '0;
            twinkle_count_reg  <= '0;
            marquee_count_reg  <= '0;
            m_valid_reg        <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TWINKLE_PERIOD: twinkle_period_reg <= cfg_data;
                    REG_MARQUEE_PERIOD: marquee_period_reg <= cfg_data;
                    default: ;
                endcase
            end
            twinkle_count_reg <= twinkle_count_next;
            marquee_count_reg <= marquee_count_next;
            m_valid_reg       <= m_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            if (skid_valid_reg)
                m_data_reg <= skid_data_reg;
            else if (in_fire)
                m_data_reg <= shown_word;
        end
        else if (in_fire && !m_valid_reg)
            m_data_reg <= shown_word;

        if (in_fire && m_valid_reg && !out_fire)
            skid_data_reg <= shown_word;
    end

    `LTMO_ASSERT_IMPLY(a_skid_needs_main, clk, rst_n, skid_valid_reg, m_valid_reg)
    `LTMO_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && !m_tready,
                      skid_valid_reg && $stable(skid_data_reg))
    `LTMO_ASSERT_NEXT(a_counts_only_on_last, clk, rst_n, !(in_fire && is_last),
                      $stable(twinkle_count_reg) && $stable(marquee_count_reg))

endmodule

@@ src/ltmo_overlay.sv @@
// ----------------------------------------------------------------------------
// ltmo_overlay
// Twinkle blanking and marquee border overlay of one column word.
// ----------------------------------------------------------------------------
module ltmo_overlay
    import ltmo_pkg::*;
(
    input  ltmo_ctrl_t        ctrl,
    input  logic [COL_W-1:0]  column_index,
    input  logic [WORD_W-1:0] column_word,
    input  logic              is_last,
    output logic [WORD_W-1:0] shown_word
);

    logic                blank;
    logic [WORD_W-1:0]   word_blanked;
    logic [PERIOD_W-1:0] quarter_len;
    logic [PERIOD_W-1:0] half_len;
    logic [PERIOD_W-1:0] three_quarter_len;
    logic [1:0]          quarter;
    logic [1:0]          phase;
    quarter_look_t       look;

    assign blank = (ctrl.twinkle_period != '0) &&
                   (ctrl.twinkle_count >= {1'b0, ctrl.twinkle_period[PERIOD_W-1:1]});
    assign word_blanked = blank ? '0 : column_word;

    assign quarter_len       = {2'b00, ctrl.marquee_period[PERIOD_W-1:2]};
    assign half_len          = {1'b0, ctrl.marquee_period[PERIOD_W-1:1]};
    assign three_quarter_len = {quarter_len[PERIOD_W-2:0], 1'b0} + quarter_len;

    always_comb
    begin
        priority if (ctrl.marquee_count < quarter_len)
            quarter = 2'd0;
        else if (ctrl.marquee_count < half_len)
            quarter = 2'd1;
        else if (ctrl.marquee_count < three_quarter_len)
            quarter = 2'd2;
        else
            quarter = 2'd3;
    end

    assign look  = quarter_look(quarter);
    assign phase = column_index[1:0];

    always_comb
    begin
        shown_word = word_blanked;
        if (ctrl.marquee_period != '0)
        begin
            if (column_index == '0)
                shown_word = look.first_word;
            if (is_last)
                shown_word = look.last_word;
            if (phase == look.top_phase)
                shown_word = shown_word | TOP_BIT;
            else
                shown_word = shown_word & ~TOP_BIT;
            if (phase == look.bottom_phase)
                shown_word = shown_word | BOTTOM_BIT;
            else
                shown_word = shown_word & ~BOTTOM_BIT;
        end
    end

endmodule

@@ sim/led_twinkle_marquee_overlay_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_twinkle_marquee_overlay_top_test
// Self-checking bench for the twinkle and marquee column overlay.
// ----------------------------------------------------------------------------
// Column words are streamed in as whole frames, short frames and stray
// columns under a range of period settings. A scoreboard keeps its own copy
// of the periods and frame counters, predicts every shown word and checks
// the output stream in order. Both stream sides idle at random, and the
// output side holds off once for long enough to back up the input.
// ----------------------------------------------------------------------------
module led_twinkle_marquee_overlay_top_test
    import ltmo_pkg::*;
();

    localparam int FRAME_COLUMNS = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 1000;
    localparam int PHASE_ITEMS   = 55;

    class overlay_scoreboard;
        logic [PERIOD_W-1:0] twinkle_period;
        logic [PERIOD_W-1:0] marquee_period;
        logic [PERIOD_W-1:0] twinkle_count;
        logic [PERIOD_W-1:0] marquee_count;
        logic [WORD_W-1:0]   expected_words[$];
        int                  failures;

        function new();
            twinkle_period = '0;
            marquee_period = '0;
            twinkle_count  = '0;
            marquee_count  = '0;
            failures       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
            if (idx == REG_TWINKLE_PERIOD)
                twinkle_period = value;
            else if (idx == REG_MARQUEE_PERIOD)
                marquee_period = value;
        endfunction

        function logic [PERIOD_W-1:0] next_count(logic [PERIOD_W-1:0] count,
                                                 logic [PERIOD_W-1:0] period);
            logic [PERIOD_W-1:0] n;
            n = count + 1'b1;
            if (n >= period)
                n = '0;
            return n;
        endfunction

        // overlay one column against the counters as they stand
        function logic [WORD_W-1:0] shown_word_for(logic [COL_W-1:0] col,
                                                   logic [WORD_W-1:0] word);
            int unsigned         mp;
            int unsigned         mc;
            int unsigned         quarter;
            logic [WORD_W-1:0]   first_w;
            logic [WORD_W-1:0]   last_w;
            logic [1:0]          top_ph;
            logic [1:0]          bot_ph;
            logic [WORD_W-1:0]   w;
            w = word;
            if (twinkle_period != 0 && twinkle_count >= twinkle_period / 2)
                w = '0;
            if (marquee_period != 0)
            begin
                mp = marquee_period;
                mc = marquee_count;
                if (mc < mp / 4)
                    quarter = 0;
                else if (mc < mp / 2)
                    quarter = 1;
                else if (mc < (mp / 4) * 3)
                    quarter = 2;
                else
                    quarter = 3;
                case (quarter)
                    0:
                    begin
                        first_w = 16'h0111; last_w = 16'h0222;
                        top_ph  = 2'd0;     bot_ph = 2'd1;
                    end
                    1:
                    begin
                        first_w = 16'h0222; last_w = 16'h0111;
                        top_ph  = 2'd3;     bot_ph = 2'd2;
                    end
                    2:
                    begin
                        first_w = 16'h0444; last_w = 16'h0888;
                        top_ph  = 2'd2;     bot_ph = 2'd3;
                    end
                    default:
                    begin
                        first_w = 16'h0888; last_w = 16'h0444;
                        top_ph  = 2'd1;     bot_ph = 2'd0;
                    end
                endcase
                if (col == 0)
                    w = first_w;
                if (col == FRAME_COLUMNS - 1)
                    w = last_w;
                if (col[1:0] == top_ph)
                    w = w | TOP_BIT;
                else
                    w = w & ~TOP_BIT;
                if (col[1:0] == bot_ph)
                    w = w | BOTTOM_BIT;
                else
                    w = w & ~BOTTOM_BIT;
            end
            return w;
        endfunction

        function void note_column(logic [COL_W-1:0] col, logic [WORD_W-1:0] word);
            expected_words.push_back(shown_word_for(col, word));
            if (col == FRAME_COLUMNS - 1)
            begin
                if (twinkle_period != 0)
                    twinkle_count = next_count(twinkle_count, twinkle_period);
                if (marquee_period != 0)
                    marquee_count = next_count(marquee_count, marquee_period);
            end
        endfunction

        function void report(string what);
            failures++;
            if (failures <= 10)
                $display("%0t: %s", $time, what);
        endfunction

        function void check_word(logic [WORD_W-1:0] actual);
            logic [WORD_W-1:0] exp_w;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected shown_word %h", actual));
                return;
            end
            exp_w = expected_words.pop_front();
            if (actual !== exp_w)
                report($sformatf("shown_word mismatch: expected %h, got %h", exp_w, actual));
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void finish_check();
            if (expected_words.size() != 0)
                report($sformatf("%0d results never arrived", expected_words.size()));
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PERIOD_W-1:0]  cfg_data  = '0;

    overlay_scoreboard sb = new();
    bit                s_eager;
    bit                hold_req    = 1'b0;
    int                idle_cycles = 0;

    led_twinkle_marquee_overlay_top #(.COLUMNS(FRAME_COLUMNS)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return WORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic send_column(input logic [COL_W-1:0] col, input logic [WORD_W-1:0] word);
        int gap;
        gap = s_eager ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, word, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_column(col, word);
    endtask

    // stop offering and let every outstanding transaction drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_periods(input logic [PERIOD_W-1:0] tw, input logic [PERIOD_W-1:0] mq);
        drain();
        write_reg(REG_TWINKLE_PERIOD, tw);
        write_reg(REG_MARQUEE_PERIOD, mq);
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] tw, input logic [PERIOD_W-1:0] mq);
        int sent;
        int kind;
        int n;
        set_periods(tw, mq);
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            s_eager = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 9);
            if (kind < 3)
            begin
                for (int c = 0; c < FRAME_COLUMNS; c++)
                    send_column(COL_W'(c), random_word());
                sent += FRAME_COLUMNS;
            end
            else if (kind < 8)
            begin
                n = $urandom_range(0, 6);
                send_column('0, random_word());
                repeat (n)
                    send_column(COL_W'($urandom_range(1, FRAME_COLUMNS - 2)), random_word());
                send_column(COL_W'(FRAME_COLUMNS - 1), random_word());
                sent += n + 2;
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_column(COL_W'($urandom_range(0, 63)), random_word());
                sent += n;
            end
        end
    endtask

    // output side: random stalls, bursts without stalls, one long hold-off
    initial
    begin
        int  stall;
        int  results;
        bit  r_eager;
        bit  hold_done;
        results   = 0;
        r_eager   = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_word(m_tdata);
                results++;
                if (results % 32 == 0)
                    r_eager = ($urandom_range(0, 3) == 0);
                stall = r_eager ? 0 : $urandom_range(0, 16);
                if (hold_req && !hold_done)
                begin
                    stall     = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [PERIOD_W-1:0] tw_list[7];
        logic [PERIOD_W-1:0] mq_list[7];
        logic [PERIOD_W-1:0] tw;
        logic [PERIOD_W-1:0] mq;
        tw_list = '{8'd0, 8'd1, 8'd255, 8'd1, 8'd255, 8'd3, 8'd4};
        mq_list = '{8'd0, 8'd1, 8'd255, 8'd255, 8'd2, 8'd5, 8'd8};
        s_eager     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // periods at reset: words pass untouched, column 47 and stray indexes
        send_column(6'd0,  16'h0000);
        send_column(6'd47, 16'hFFFF);
        send_column(6'd63, 16'hAAAA);
        send_column(6'd48, 16'h5555);
        send_column(6'd21, 16'hFFFF);

        // largest periods: push both counters up to six
        set_periods(8'd255, 8'd255);
        repeat (3)
        begin
            send_column(6'd47, 16'hFFFF);
            send_column(6'd47, 16'h0000);
        end
        send_column(6'd0,  16'hFFFF);
        send_column(6'd63, 16'hFFFF);
        send_column(6'd1,  16'h0000);

        // lowered periods leave the counts above them; next advance wraps
        set_periods(8'd2, 8'd4);
        send_column(6'd0,  16'hFFFF);
        send_column(6'd47, 16'hFFFF);
        send_column(6'd0,  16'hFFFF);
        send_column(6'd1,  16'hFFFF);
        send_column(6'd2,  16'hFFFF);
        send_column(6'd3,  16'hFFFF);
        send_column(6'd47, 16'hFFFF);
        send_column(6'd33, 16'h1234);
        send_column(6'd47, 16'h8001);

        for (int p = 0; p < 11; p++)
        begin
            if (p < 7)
            begin
                tw = tw_list[p];
                mq = mq_list[p];
            end
            else
            begin
                tw = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom_range(0, 255))
                                                 : PERIOD_W'($urandom_range(0, 12));
                mq = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom_range(0, 255))
                                                 : PERIOD_W'($urandom_range(0, 12));
            end
            if (p == 2)
                hold_req = 1'b1;
            run_phase(tw, mq);
        end

        drain();
        repeat (10) @(posedge clk);
        sb.finish_check();
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ltmo_pkg.sv
src/ltmo_overlay.sv
src/led_twinkle_marquee_overlay_top.sv
sim/led_twinkle_marquee_overlay_top_test.sv
